// ===== src/bte_pkg.sv =====
// bte_pkg: shared types and constants of the battery time estimator
// used by bte_divider and battery_time_estimator
`timescale 1ns / 1ps
package bte_pkg;

    localparam int DIV_W    = 64;
    localparam int DVSR_W   = 14;
    localparam int FACTOR_W = 48;

    localparam logic [2:0] ST_ESTIMATE = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_SAME     = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_NONE     = 3'd4;

    localparam logic [1:0] REG_FULL_SCALE = 2'd0;
    localparam logic [1:0] REG_THRESHOLD  = 2'd1;

    typedef struct packed {
        logic [13:0] reading;
        logic [31:0] stamp_seconds;
        logic        charger_attached;
        logic        charger_status_ok;
        logic        charge_complete;
        logic        woke_from_suspend;
    } sample_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        toward_full;
        logic [31:0] estimate_seconds;
    } result_t;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic              neg;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/bte_divider.sv =====
// bte_divider: restoring divider, one quotient bit per cycle
// depends on bte_pkg
`timescale 1ns / 1ps
module bte_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  bte_pkg::div_req_t req,
    output bte_pkg::div_rsp_t rsp
);
    logic [bte_pkg::DVSR_W-1:0] rem_reg;
    logic [bte_pkg::DIV_W-1:0]  quo_reg;
    logic [bte_pkg::DVSR_W-1:0] dvsr_reg;
    logic                       neg_reg;
    logic [6:0]                 cnt_reg;
    logic                       done_reg;
    logic [bte_pkg::DVSR_W:0]   rem_sh;
    logic                       fits;

    // one shift and trial subtract
    assign rem_sh = {rem_reg, quo_reg[bte_pkg::DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dvsr_reg};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                cnt_reg <= 7'(bte_pkg::DIV_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= '0;
            quo_reg  <= req.dividend;
            dvsr_reg <= req.divisor;
            neg_reg  <= req.neg;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? bte_pkg::DVSR_W'(rem_sh - {1'b0, dvsr_reg})
                            : rem_sh[bte_pkg::DVSR_W-1:0];
            quo_reg <= {quo_reg[bte_pkg::DIV_W-2:0], fits};
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

endmodule

// ===== src/battery_time_estimator.sv =====
// battery_time_estimator: top level, sequencer, sample history and estimate
// depends on bte_pkg and bte_divider
`timescale 1ns / 1ps
// Usage
// sample channel: one battery reading per transaction (sample_valid/ready).
// result channel: one result per sample (result_valid/ready), in order.
// cfg channel: cfg_index 0 writes full_scale, 1 writes full_threshold_pct;
//   always ready, write only while no sample is in flight.
// Sequence: a rejected or fully charged reading goes from evaluation straight
// to the result stage, a reading that leaves fewer than two samples through
// the multiply. Other readings walk up to WINDOW sample pairs, each with a
// registered history fetch and, when the readings differ, a division, then
// one mean division and the multiply. The one 64-bit restoring divider, a
// bit per cycle, serves all of these divisions.
// One sample is processed at a time; sample_ready is high only when idle.
// A finished result waits in an output register; a new sample may be taken
// while it waits, but that sample's result is held until the old one leaves.
// Reset: discharging mode, empty history, both kept factors at -1.0,
// full_scale 100, threshold 98 percent. No clearing pass is needed.
module battery_time_estimator #(
    parameter int WINDOW        = 10,
    parameter int FRACTION_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  bte_pkg::sample_t  sample,
    output logic              result_valid,
    input  logic              result_ready,
    output bte_pkg::result_t  result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [13:0]       cfg_data
);
    localparam int HDEPTH = WINDOW + 1;
    localparam int PTR_W  = $clog2(HDEPTH);
    localparam int FILL_W = $clog2(HDEPTH + 1);
    localparam int FW     = bte_pkg::FACTOR_W;
    localparam logic signed [FW-1:0] FACTOR_RESET = -(FW'(1) <<< FRACTION_BITS);
    localparam logic signed [63:0] FMAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] FMIN = -FMAX - 64'sd1;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_FETCH = 4'd2;
    localparam logic [3:0] S_CAPT  = 4'd3;
    localparam logic [3:0] S_DIVW  = 4'd4;
    localparam logic [3:0] S_MEAN  = 4'd5;
    localparam logic [3:0] S_MEANW = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]               state_reg;
    bte_pkg::sample_t         smp_reg;
    logic [13:0]              full_scale_reg;
    logic [6:0]               pct_reg;
    logic [13:0]              last_reg;
    logic                     mode_reg;
    logic [FILL_W-1:0]        fill_reg;
    logic [PTR_W-1:0]         newest_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [FILL_W-1:0]        k_reg;
    logic                     have_newer_reg;
    logic signed [FW-1:0]     factor_reg [2];
    logic signed [63:0]       total_reg;
    logic [31:0]              newer_stamp_reg;
    logic [13:0]              newer_rd_reg;
    logic [31:0]              q_stamp_reg;
    logic [13:0]              q_rd_reg;
    logic [31:0]              mem_stamp [HDEPTH];
    logic [13:0]              mem_rd [HDEPTH];
    logic signed [62:0]       prod_reg;
    logic                     early_reg;
    logic [2:0]               early_stat_reg;
    logic                     res_valid_reg;
    bte_pkg::result_t         res_reg;
    bte_pkg::div_req_t        dreq;
    bte_pkg::div_rsp_t        drsp;

    // evaluation of a new reading
    logic                     mode_chg;
    logic                     mode_new;
    logic [13:0]              fs_eff;
    logic                     at_full;
    logic                     clr;
    logic [FILL_W-1:0]        fill_eff;
    logic [PTR_W-1:0]         newest_new;
    logic [FILL_W-1:0]        fill_new;

    // pair arithmetic
    logic signed [32:0]       dt;
    logic [32:0]              dt_mag;
    logic signed [14:0]       dc;
    logic [13:0]              dc_mag;
    logic                     more_pairs;
    logic signed [63:0]       mean_sat;
    logic signed [14:0]       mul_op;
    logic signed [62:0]       scaled;
    logic                     out_free;

    assign mode_chg = smp_reg.charger_status_ok && (smp_reg.charger_attached != mode_reg);
    assign mode_new = mode_chg ? smp_reg.charger_attached : mode_reg;
    assign fs_eff   = (full_scale_reg == '0) ? 14'd1 : full_scale_reg;
    assign at_full  = mode_new && smp_reg.charge_complete
                      && ((21'(smp_reg.reading) * 21'd100) >= (21'(pct_reg) * 21'(fs_eff)));
    assign clr      = mode_chg || (!mode_new && smp_reg.woke_from_suspend);
    assign fill_eff = clr ? '0 : fill_reg;
    assign newest_new = (fill_eff == '0) ? '0 :
                        (newest_reg == PTR_W'(HDEPTH - 1)) ? '0 : newest_reg + PTR_W'(1);
    assign fill_new = (fill_eff == FILL_W'(HDEPTH)) ? fill_eff : fill_eff + FILL_W'(1);

    assign dt     = $signed({1'b0, newer_stamp_reg}) - $signed({1'b0, q_stamp_reg});
    assign dt_mag = dt[32] ? 33'(-dt) : 33'(dt);
    assign dc     = $signed({1'b0, newer_rd_reg}) - $signed({1'b0, q_rd_reg});
    assign dc_mag = dc[14] ? 14'(-dc) : 14'(dc);
    // another pair follows the current one
    assign more_pairs = (k_reg + FILL_W'(2)) < fill_reg;

    assign mean_sat = (drsp.quotient > FMAX) ? FMAX :
                      (drsp.quotient < FMIN) ? FMIN : drsp.quotient;
    assign mul_op   = mode_reg ? ($signed({1'b0, full_scale_reg}) - $signed({1'b0, smp_reg.reading}))
                               : $signed({1'b0, smp_reg.reading});
    // divide by 2^F rounding toward zero
    assign scaled   = (prod_reg + (prod_reg[62] ? 63'((64'sd1 <<< FRACTION_BITS) - 64'sd1)
                                                : 63'sd0)) >>> FRACTION_BITS;
    assign out_free = !res_valid_reg || result_ready;

    // divider requests
    always_comb
    begin
        dreq = '0;
        if (state_reg == S_CAPT && have_newer_reg && dc_mag != '0)
        begin
            dreq.start    = 1'b1;
            dreq.neg      = dt[32];
            dreq.dividend = 64'(dt_mag) << FRACTION_BITS;
            dreq.divisor  = dc_mag;
        end
        else if (state_reg == S_MEAN)
        begin
            dreq.start    = 1'b1;
            dreq.neg      = total_reg[63];
            dreq.dividend = total_reg[63] ? 64'(-total_reg) : 64'(total_reg);
            dreq.divisor  = bte_pkg::DVSR_W'(k_reg);
        end
    end

    bte_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            full_scale_reg <= 14'd100;
            pct_reg        <= 7'd98;
            last_reg       <= '0;
            mode_reg       <= 1'b0;
            fill_reg       <= '0;
            newest_reg     <= '0;
            factor_reg[0]  <= FACTOR_RESET;
            factor_reg[1]  <= FACTOR_RESET;
            res_valid_reg  <= 1'b0;
            have_newer_reg <= 1'b0;
            k_reg          <= '0;
            early_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    bte_pkg::REG_FULL_SCALE: full_scale_reg <= cfg_data;
                    bte_pkg::REG_THRESHOLD:  pct_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
            if (res_valid_reg && result_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (sample_valid)
                    begin
                        state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    k_reg          <= '0;
                    have_newer_reg <= 1'b0;
                    if (smp_reg.reading == '0 || smp_reg.reading == last_reg)
                    begin
                        early_reg <= 1'b1;
                        state_reg <= S_FIN;
                    end
                    else
                    begin
                        last_reg <= smp_reg.reading;
                        mode_reg <= mode_new;
                        if (at_full)
                        begin
                            fill_reg   <= '0;
                            newest_reg <= '0;
                            early_reg  <= 1'b1;
                            state_reg  <= S_FIN;
                        end
                        else
                        begin
                            fill_reg   <= fill_new;
                            newest_reg <= newest_new;
                            early_reg  <= 1'b0;
                            state_reg  <= (fill_new >= FILL_W'(2)) ? S_FETCH : S_MUL;
                        end
                    end
                end
                S_FETCH:
                begin
                    state_reg <= S_CAPT;
                end
                S_CAPT:
                begin
                    if (!have_newer_reg)
                    begin
                        have_newer_reg <= 1'b1;
                        state_reg      <= S_FETCH;
                    end
                    else if (dc_mag != '0)
                    begin
                        state_reg <= S_DIVW;
                    end
                    else
                    begin
                        k_reg     <= k_reg + FILL_W'(1);
                        state_reg <= more_pairs ? S_FETCH : S_MEAN;
                    end
                end
                S_DIVW:
                begin
                    if (drsp.done)
                    begin
                        k_reg     <= k_reg + FILL_W'(1);
                        state_reg <= more_pairs ? S_FETCH : S_MEAN;
                    end
                end
                S_MEAN:
                begin
                    state_reg <= S_MEANW;
                end
                S_MEANW:
                begin
                    if (drsp.done)
                    begin
                        factor_reg[mode_reg] <= FW'(mean_sat);
                        state_reg            <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        res_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers, history memory and arithmetic
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && sample_valid)
        begin
            smp_reg <= sample;
        end
        if (state_reg == S_EVAL)
        begin
            total_reg      <= '0;
            ptr_reg        <= newest_new;
            early_stat_reg <= (smp_reg.reading == '0) ? bte_pkg::ST_INVALID :
                              (smp_reg.reading == last_reg) ? bte_pkg::ST_SAME : bte_pkg::ST_FULL;
            if (smp_reg.reading != '0 && smp_reg.reading != last_reg && !at_full)
            begin
                mem_stamp[newest_new] <= smp_reg.stamp_seconds;
                mem_rd[newest_new]    <= smp_reg.reading;
            end
        end
        // registered history read, walking from newest to oldest
        if (state_reg == S_FETCH)
        begin
            q_stamp_reg <= mem_stamp[ptr_reg];
            q_rd_reg    <= mem_rd[ptr_reg];
            ptr_reg     <= (ptr_reg == '0) ? PTR_W'(HDEPTH - 1) : ptr_reg - PTR_W'(1);
        end
        if (state_reg == S_CAPT && (!have_newer_reg || dc_mag == '0))
        begin
            newer_stamp_reg <= q_stamp_reg;
            newer_rd_reg    <= q_rd_reg;
        end
        if (state_reg == S_DIVW && drsp.done)
        begin
            total_reg       <= total_reg + drsp.quotient;
            newer_stamp_reg <= q_stamp_reg;
            newer_rd_reg    <= q_rd_reg;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= 63'(mul_op) * 63'(factor_reg[mode_reg]);
        end
        if (state_reg == S_FIN && out_free)
        begin
            res_reg.toward_full <= mode_reg;
            if (early_reg)
            begin
                res_reg.status           <= early_stat_reg;
                res_reg.estimate_seconds <= '0;
            end
            else if (scaled <= 63'sd0)
            begin
                res_reg.status           <= bte_pkg::ST_NONE;
                res_reg.estimate_seconds <= '0;
            end
            else
            begin
                res_reg.status           <= bte_pkg::ST_ESTIMATE;
                res_reg.estimate_seconds <= (scaled > 63'sh0_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                        : scaled[31:0];
            end
        end
    end

    assign sample_ready = (state_reg == S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;
    assign cfg_ready    = 1'b1;

    // checks
    a_est_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == bte_pkg::ST_ESTIMATE |-> result.estimate_seconds != '0)
        else $error("estimate of zero reported as valid");
    a_est_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != bte_pkg::ST_ESTIMATE |-> result.estimate_seconds == '0)
        else $error("estimate not cleared for non-estimate status");
    a_full_mode: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == bte_pkg::ST_FULL |-> result.toward_full)
        else $error("fully charged reported while discharging");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(HDEPTH))
        else $error("history fill above depth");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready |=> !sample_ready)
        else $error("second transaction taken while busy");

endmodule
